// File: design/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int POOL_W  = 11;
    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int ALIGN_W = 8;
    localparam int BIDX_W  = 10;
    localparam int STAT_W  = 3;
    localparam int BYTES_W = 27;
    localparam int SIZE_W  = 17;
    localparam int CFGI_W  = 2;

    localparam logic [ALIGN_W-1:0] ALIGN_FOUR = 8'd4;
    localparam logic [POOL_W-1:0]  BLK_MAX    = 11'h7FF;
    localparam logic [BYTES_W-1:0] BYTE_MAX   = 27'h7FF_FFFF;
    localparam logic [SIZE_W-1:0]  SIZE_MIN   = 17'd4;
    localparam logic [SIZE_W-1:0]  SIZE_RST   = 17'd16;
    localparam logic [REQ_W-1:0]   SIZE_RND   = 16'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_SIZE  = 3'd2,
        ST_ALIGN = 3'd3,
        ST_INDEX = 3'd4
    } status_t;

    typedef enum logic [CFGI_W-1:0] {
        CFG_POOL_BLOCKS = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BASE_ADDR   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

endpackage

// File: design/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool allocator with a LIFO free list of block indices.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request item: an allocate
// (operation 0) or a free (operation 1). Output channel (out_valid /
// out_stall) returns one result item per request: status, granted index and
// address, and the current and peak block and byte counts after the request.
// Configuration writes use cfg_valid / cfg_ready with cfg_index 0 pool
// blocks, 1 block size request, 2 base address; cfg_ready is always high.
// out_valid rises in the cycle after acceptance; one item per cycle is
// sustained while the receiver does not stall. The free list lives in a
// one-port-write, one-port-read memory; its link for the current head is read
// every cycle and a push is forwarded around the memory so the next pop needs no wait.
// After reset the block sweeps all MAX_BLOCKS entries of the link memory, one
// entry a cycle, and holds in_stall high meanwhile; counters and head
// clear at once. When the receiver stalls, the result item holds in the
// output register and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [ALIGN_W-1:0]  alignment_bytes,
    input  logic [BIDX_W-1:0]   block_index,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic [BIDX_W-1:0]   granted_index,
    output logic [ADDR_W-1:0]   granted_address,
    output logic [POOL_W-1:0]   blocks_in_use,
    output logic [BYTES_W-1:0]  bytes_in_use,
    output logic [POOL_W-1:0]   peak_blocks,
    output logic [BYTES_W-1:0]  peak_bytes,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFGI_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int CMP_W  = (LINK_W > POOL_W) ? LINK_W : POOL_W;
    localparam int N_RST  = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
    localparam logic [CMP_W-1:0]  N_MAX    = CMP_W'(MAX_BLOCKS);
    localparam logic [LINK_W-1:0] CLR_LAST = LINK_W'(MAX_BLOCKS - 1);

    logic [LINK_W-1:0] next_link_mem [MAX_BLOCKS];

    logic [CMP_W-1:0]   eff_n_reg;
    logic [SIZE_W-1:0]  eff_size_reg;
    logic [ADDR_W-1:0]  base0_reg;

    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  rd_data_reg;
    logic               byp_reg;
    logic [LINK_W-1:0]  byp_val_reg;

    logic               clearing_reg;
    logic [LINK_W-1:0]  clr_cnt_reg;

    logic [POOL_W-1:0]  used_blocks_reg, used_blocks_next;
    logic [BYTES_W-1:0] used_bytes_reg, used_bytes_next;
    logic [POOL_W-1:0]  high_blocks_reg, high_blocks_next;
    logic [BYTES_W-1:0] high_bytes_reg, high_bytes_next;

    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [BIDX_W-1:0]  gidx_reg, gidx_next;
    logic [ADDR_W-1:0]  gaddr_reg, gaddr_next;

    logic               accept;
    logic               alloc_ok;
    logic               free_ok;
    logic [LINK_W-1:0]  cur_link;
    logic [CMP_W-1:0]   head_cmp;
    logic [CMP_W-1:0]   idx_cmp;
    logic [SIZE_W-1:0]  req_ext;
    logic [BYTES_W:0]   bytes_sum;
    logic [POOL_W-1:0]  pool_w;
    logic [CMP_W-1:0]   pool_cmp;
    logic [REQ_W:0]     size_rnd;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [LINK_W-1:0]  mem_wdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = clearing_reg || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;

    assign cur_link  = byp_reg ? byp_val_reg : rd_data_reg;
    assign head_cmp  = CMP_W'(free_head_reg);
    assign idx_cmp   = CMP_W'(block_index);
    assign req_ext   = SIZE_W'(request_size);
    assign bytes_sum = (BYTES_W+1)'(used_bytes_reg) + (BYTES_W+1)'(eff_size_reg);

    // pop / push decision and counter updates
    always_comb
    begin
        status_next      = ST_OK;
        gidx_next        = '0;
        gaddr_next       = '0;
        alloc_ok         = 1'b0;
        free_ok          = 1'b0;
        free_head_next   = free_head_reg;
        used_blocks_next = used_blocks_reg;
        used_bytes_next  = used_bytes_reg;
        high_blocks_next = high_blocks_reg;
        high_bytes_next  = high_bytes_reg;

        if (operation == OP_ALLOC)
        begin
            if (req_ext > eff_size_reg)
                status_next = ST_SIZE;
            else if (alignment_bytes != ALIGN_FOUR)
                status_next = ST_ALIGN;
            else if (head_cmp >= eff_n_reg)
                status_next = ST_EMPTY;
            else
            begin
                alloc_ok       = accept;
                gidx_next      = BIDX_W'(free_head_reg);
                gaddr_next     = base0_reg + ADDR_W'(free_head_reg) * ADDR_W'(eff_size_reg);
                free_head_next = cur_link;
                if (used_blocks_reg != BLK_MAX)
                    used_blocks_next = used_blocks_reg + 1'b1;
                if (bytes_sum > (BYTES_W+1)'(BYTE_MAX))
                    used_bytes_next = BYTE_MAX;
                else
                    used_bytes_next = BYTES_W'(bytes_sum);
                if (used_blocks_next > high_blocks_reg)
                    high_blocks_next = used_blocks_next;
                if (used_bytes_next > high_bytes_reg)
                    high_bytes_next = used_bytes_next;
            end
        end
        else
        begin
            if (idx_cmp >= eff_n_reg || used_blocks_reg == '0)
                status_next = ST_INDEX;
            else
            begin
                free_ok          = accept;
                free_head_next   = LINK_W'(block_index);
                used_blocks_next = used_blocks_reg - 1'b1;
                if (used_bytes_reg > BYTES_W'(eff_size_reg))
                    used_bytes_next = used_bytes_reg - BYTES_W'(eff_size_reg);
                else
                    used_bytes_next = '0;
            end
        end

        if (!(alloc_ok || free_ok))
        begin
            free_head_next   = free_head_reg;
            used_blocks_next = used_blocks_reg;
            used_bytes_next  = used_bytes_reg;
            high_blocks_next = high_blocks_reg;
            high_bytes_next  = high_bytes_reg;
        end
    end

    // link memory: sweep after reset, push link on free
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[IDX_W-1:0];
            mem_wdata = clr_cnt_reg + 1'b1;
        end
        else
        begin
            mem_we    = free_ok;
            mem_waddr = IDX_W'(block_index);
            mem_wdata = free_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            next_link_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= next_link_mem[free_head_next[IDX_W-1:0]];
    end

    // config decode into effective values
    assign pool_w   = cfg_data[POOL_W-1:0];
    assign pool_cmp = CMP_W'(pool_w);
    assign size_rnd = ((REQ_W+1)'(cfg_data[REQ_W-1:0]) + (REQ_W+1)'(SIZE_RND))
                      & ~(REQ_W+1)'(SIZE_RND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_n_reg    <= CMP_W'(N_RST);
            eff_size_reg <= SIZE_RST;
            base0_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POOL_BLOCKS:
                begin
                    if (pool_cmp == '0)
                        eff_n_reg <= CMP_W'(1);
                    else if (pool_cmp > N_MAX)
                        eff_n_reg <= N_MAX;
                    else
                        eff_n_reg <= pool_cmp;
                end
                CFG_BLOCK_SIZE:
                begin
                    if (SIZE_W'(size_rnd) < SIZE_MIN)
                        eff_size_reg <= SIZE_MIN;
                    else
                        eff_size_reg <= SIZE_W'(size_rnd);
                end
                CFG_BASE_ADDR:
                    base0_reg <= (cfg_data + ADDR_W'(SIZE_RND)) & ~ADDR_W'(SIZE_RND);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            free_head_reg   <= '0;
            byp_reg         <= 1'b0;
            byp_val_reg     <= '0;
            used_blocks_reg <= '0;
            used_bytes_reg  <= '0;
            high_blocks_reg <= '0;
            high_bytes_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            free_head_reg   <= free_head_next;
            byp_reg         <= free_ok;
            byp_val_reg     <= free_head_reg;
            used_blocks_reg <= used_blocks_next;
            used_bytes_reg  <= used_bytes_next;
            high_blocks_reg <= high_blocks_next;
            high_bytes_reg  <= high_bytes_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            gidx_reg   <= gidx_next;
            gaddr_reg  <= gaddr_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_index   = gidx_reg;
    assign granted_address = gaddr_reg;
    assign blocks_in_use   = used_blocks_reg;
    assign bytes_in_use    = used_bytes_reg;
    assign peak_blocks     = high_blocks_reg;
    assign peak_bytes      = high_bytes_reg;

endmodule
